FILE: sv/fpml_pkg.sv
// shared types and constants for the damped field update pipeline
package fpml_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 17;
  localparam int CapMargin = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COURANT  = 3'd0,
    CFG_CENTER   = 3'd1,
    CFG_RADIUS   = 3'd2,
    CFG_ONSET    = 3'd3,
    CFG_STRENGTH = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    KIND_E = 1'b0,
    KIND_B = 1'b1
  } field_kind_e;

  typedef struct packed {
    logic [16:0] courant;
    logic [16:0] center;
    logic [16:0] radius;
    logic [15:0] onset;
    logic [16:0] strength;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] old;
    logic [33:0] curl;
  } side_t;

endpackage

FILE: sv/fpml_profile.sv
// absorber profile pipeline: y position to damping strength in q16
module fpml_profile (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fpml_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [16:0]    y_i,
  input  fpml_pkg::side_t side_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [16:0]    damp_o,
  output fpml_pkg::side_t side_o
);
  import fpml_pkg::*;

  localparam int DivSteps  = 2;
  localparam int DivStages = 16 / DivSteps;
  localparam int DivFirst  = 2;
  localparam int StSq      = DivFirst + DivStages;
  localparam int StCube    = StSq + 1;
  localparam int StDamp    = StCube + 1;
  localparam int NStg      = StDamp + 1;
  localparam logic [15:0] Cap = 16'(65536 - CapMargin);

  typedef struct packed {
    logic        zero;
    logic        big;
    logic [32:0] lhs;
    logic [32:0] thr;
    logic [33:0] rem;
    logic [33:0] dv;
    logic [15:0] tq;
    logic [31:0] sq;
    logic [15:0] m;
    logic [16:0] damp;
    side_t       side;
  } pst_t;

  pst_t            st_d [NStg];
  pst_t            st_q [NStg];
  logic [NStg-1:0] v_q;
  logic [NStg-1:0] vin;
  logic [NStg-1:0] rdy;

  assign vin = {v_q[NStg-2:0], in_valid_i};

  always_comb begin
    rdy[NStg-1] = ~v_q[NStg-1] | out_ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end

  always_comb begin
    logic [16:0] rad;
    logic [16:0] dy;
    logic [32:0] diff;
    logic [34:0] r2;
    logic [47:0] t3;
    logic [15:0] cube;
    logic [32:0] pd;
    // prepare distance, onset threshold and divisor
    st_d[0] = '0;
    rad = (cfg_i.radius == 17'd0) ? 17'd1 : cfg_i.radius;
    dy = (y_i >= cfg_i.center) ? (y_i - cfg_i.center) : (cfg_i.center - y_i);
    st_d[0].lhs  = {dy, 16'd0};
    st_d[0].thr  = 33'(cfg_i.onset) * 33'(rad);
    st_d[0].dv   = 34'(rad) * 34'(17'h10000 - {1'b0, cfg_i.onset});
    st_d[0].side = side_i;
    // threshold and saturation compare
    st_d[1] = st_q[0];
    diff = st_q[0].lhs - st_q[0].thr;
    st_d[1].zero = st_q[0].lhs <= st_q[0].thr;
    st_d[1].big  = {1'b0, diff} >= st_q[0].dv;
    st_d[1].rem  = 34'(diff);
    // restoring division for the normalised depth
    for (int k = DivFirst; k < StSq; k++) begin
      st_d[k] = st_q[k-1];
      for (int j = 0; j < DivSteps; j++) begin
        r2 = {st_d[k].rem, 1'b0};
        if (r2 >= {1'b0, st_d[k].dv}) begin
          st_d[k].rem = 34'(r2 - {1'b0, st_d[k].dv});
          st_d[k].tq  = {st_d[k].tq[14:0], 1'b1};
        end else begin
          st_d[k].rem = r2[33:0];
          st_d[k].tq  = {st_d[k].tq[14:0], 1'b0};
        end
      end
    end
    st_d[StSq] = st_q[StSq-1];
    st_d[StSq].sq = 32'(st_q[StSq-1].tq) * 32'(st_q[StSq-1].tq);
    st_d[StCube] = st_q[StCube-1];
    t3 = 48'(st_q[StCube-1].sq) * 48'(st_q[StCube-1].tq) + 48'h8000_0000;
    cube = t3[47:32];
    if (st_q[StCube-1].big || cube >= Cap) begin
      st_d[StCube].m = Cap;
    end else begin
      st_d[StCube].m = cube;
    end
    st_d[StDamp] = st_q[StDamp-1];
    pd = 33'(cfg_i.strength) * 33'(st_q[StDamp-1].m) + 33'h8000;
    st_d[StDamp].damp = st_q[StDamp-1].zero ? 17'd0 : pd[32:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (rdy[k]) v_q[k] <= vin[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NStg; k++) begin
      if (rdy[k] && vin[k]) st_q[k] <= st_d[k];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NStg-1];
  assign damp_o      = st_q[NStg-1].damp;
  assign side_o      = st_q[NStg-1].side;

endmodule

FILE: sv/fpml_update.sv
// damped update pipeline: products, rounding division and saturation
module fpml_update (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [16:0]     courant_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [16:0]     damp_i,
  input  fpml_pkg::side_t side_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     new_value_o,
  output logic            saturated_o
);
  import fpml_pkg::*;

  localparam int NumW      = 54;
  localparam int DivSteps  = 3;
  localparam int DivStages = NumW / DivSteps;
  localparam int DivFirst  = 4;
  localparam int StOut     = DivFirst + DivStages;
  localparam int NStg      = StOut + 1;

  typedef struct packed {
    logic [31:0]     old;
    logic [33:0]     curl;
    logic [18:0]     a;
    logic [18:0]     den;
    logic [18:0]     cmul;
    logic [51:0]     p1;
    logic [53:0]     p2;
    logic [54:0]     num;
    logic            neg;
    logic [NumW-1:0] nq;
    logic [18:0]     rem;
    logic [31:0]     res;
    logic            sat;
  } ust_t;

  ust_t            st_d [NStg];
  ust_t            st_q [NStg];
  logic [NStg-1:0] v_q;
  logic [NStg-1:0] vin;
  logic [NStg-1:0] rdy;

  assign vin = {v_q[NStg-2:0], in_valid_i};

  always_comb begin
    rdy[NStg-1] = ~v_q[NStg-1] | out_ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end

  always_comb begin
    logic [17:0]     g18;
    logic [54:0]     mag;
    logic [19:0]     r2;
    logic [NumW-1:0] qm;
    // coefficients from damping and kind
    st_d[0] = '0;
    g18 = (side_i.kind == KIND_B) ? {1'b0, damp_i} : {damp_i, 1'b0};
    st_d[0].a    = 19'h40000 - {1'b0, g18};
    st_d[0].den  = 19'h40000 + {1'b0, g18};
    st_d[0].cmul = (side_i.kind == KIND_B) ? {1'b0, courant_i, 1'b0} : {courant_i, 2'b00};
    st_d[0].old  = side_i.old;
    st_d[0].curl = side_i.curl;
    st_d[1] = st_q[0];
    st_d[1].p1 = $signed(st_q[0].old) * $signed({1'b0, st_q[0].a});
    st_d[1].p2 = $signed(st_q[0].curl) * $signed({1'b0, st_q[0].cmul});
    st_d[2] = st_q[1];
    st_d[2].num = {{3{st_q[1].p1[51]}}, st_q[1].p1} + {st_q[1].p2[53], st_q[1].p2};
    // magnitude with half divisor added for round to nearest
    st_d[3] = st_q[2];
    st_d[3].neg = st_q[2].num[54];
    mag = (st_q[2].num[54] ? ~st_q[2].num : st_q[2].num) + 55'(st_q[2].den >> 1)
          + 55'(st_q[2].num[54]);
    st_d[3].nq  = mag[NumW-1:0];
    st_d[3].rem = '0;
    for (int k = DivFirst; k < StOut; k++) begin
      st_d[k] = st_q[k-1];
      for (int j = 0; j < DivSteps; j++) begin
        r2 = {st_d[k].rem, st_d[k].nq[NumW-1]};
        if (r2 >= {1'b0, st_d[k].den}) begin
          st_d[k].rem = 19'(r2 - {1'b0, st_d[k].den});
          st_d[k].nq  = {st_d[k].nq[NumW-2:0], 1'b1};
        end else begin
          st_d[k].rem = r2[18:0];
          st_d[k].nq  = {st_d[k].nq[NumW-2:0], 1'b0};
        end
      end
    end
    // clip to the 32-bit range
    st_d[StOut] = st_q[StOut-1];
    qm = st_q[StOut-1].nq;
    if (!st_q[StOut-1].neg && qm > NumW'(32'h7FFF_FFFF)) begin
      st_d[StOut].res = 32'h7FFF_FFFF;
      st_d[StOut].sat = 1'b1;
    end else if (st_q[StOut-1].neg && qm > NumW'(32'h8000_0000)) begin
      st_d[StOut].res = 32'h8000_0000;
      st_d[StOut].sat = 1'b1;
    end else begin
      st_d[StOut].res = st_q[StOut-1].neg ? (~qm[31:0] + 32'd1) : qm[31:0];
      st_d[StOut].sat = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (rdy[k]) v_q[k] <= vin[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NStg; k++) begin
      if (rdy[k] && vin[k]) st_q[k] <= st_d[k];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NStg-1];
  assign new_value_o = st_q[NStg-1].res;
  assign saturated_o = st_q[NStg-1].sat;

endmodule

FILE: sv/fdtd_pml_field_update.sv
// top level: configuration registers, curl sum and the two pipeline sections
// stages: the two restoring dividers (8 profile stages, 18 update stages) plus
// the product stages
// throughput: one item per cycle; each stage holds under stall and fills bubbles
// reset: valid bits and config registers reset; stage data registers do not
module fdtd_pml_field_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fpml_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fpml_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          field_kind_i,
  input  logic [16:0]                   y_half_i,
  input  logic signed [31:0]            old_value_i,
  input  logic signed [31:0]            plus_a_i,
  input  logic signed [31:0]            minus_a_i,
  input  logic signed [31:0]            plus_b_i,
  input  logic signed [31:0]            minus_b_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            new_value_o,
  output logic                          saturated_o
);
  import fpml_pkg::*;

  cfg_t        cfg_q;
  side_t       side_in;
  side_t       side_mid;
  logic        mid_valid;
  logic        mid_ready;
  logic [16:0] damp_mid;
  logic [31:0] res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.courant  <= 17'd29491;
      cfg_q.center   <= 17'd0;
      cfg_q.radius   <= 17'd2;
      cfg_q.onset    <= 16'd52429;
      cfg_q.strength <= 17'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_COURANT:  cfg_q.courant  <= cfg_data_i;
        CFG_CENTER:   cfg_q.center   <= cfg_data_i;
        CFG_RADIUS:   cfg_q.radius   <= cfg_data_i;
        CFG_ONSET:    cfg_q.onset    <= cfg_data_i[15:0];
        CFG_STRENGTH: cfg_q.strength <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // curl sum of the two neighbour pairs
  assign side_in.kind = field_kind_i;
  assign side_in.old  = old_value_i;
  assign side_in.curl = (34'(plus_a_i) - 34'(minus_a_i)) + (34'(plus_b_i) - 34'(minus_b_i));

  fpml_profile u_profile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .y_i         (y_half_i),
    .side_i      (side_in),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .damp_o      (damp_mid),
    .side_o      (side_mid)
  );

  fpml_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .courant_i   (cfg_q.courant),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .damp_i      (damp_mid),
    .side_i      (side_mid),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .new_value_o (res),
    .saturated_o (saturated_o)
  );

  assign new_value_o = $signed(res);

endmodule
